// ===== hw/rtl/aio_pkg.sv =====
// shared types and constants for the arcade i/o port block
package aio_pkg;

  // operation codes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_BUTTON = 2'd2;

  // read ports
  localparam logic [7:0] PORT_IN0       = 8'd0;
  localparam logic [7:0] PORT_IN1       = 8'd1;
  localparam logic [7:0] PORT_IN2       = 8'd2;
  localparam logic [7:0] PORT_SHIFT_OUT = 8'd3;

  // write ports
  localparam logic [7:0] PORT_SHIFT_COUNT = 8'd2;
  localparam logic [7:0] PORT_SOUND_ONE   = 8'd3;
  localparam logic [7:0] PORT_SHIFT_DATA  = 8'd4;
  localparam logic [7:0] PORT_SOUND_TWO   = 8'd5;

  // button word selectors
  localparam logic [7:0] PLAYER_ONE = 8'd1;
  localparam logic [7:0] PLAYER_TWO = 8'd2;

  localparam logic [2:0] SHIFT_COUNT_MASK  = 3'h7;
  localparam logic [7:0] SECOND_WORD_RESET = 8'h03;
  localparam logic [7:0] IN0_VALUE         = 8'd1;
  localparam logic [3:0] SHIFT_BASE        = 4'd8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] port;
    logic [7:0] write_data;
    logic [2:0] button_bit;
    logic       pressed;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       loop_start;
    logic       loop_stop;
    logic [7:0] sound_triggers;
  } result_t;

endpackage

// ===== hw/rtl/aio_core.sv =====
// port state registers and the per-access read, shift, button and edge logic
module aio_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  aio_pkg::item_t  item,
  output aio_pkg::result_t result
);

  logic [15:0] shift_word;
  logic [2:0]  shift_count;
  logic [7:0]  first_player_word;
  logic [7:0]  second_player_word;
  logic [7:0]  last_sound_one;
  logic [7:0]  last_sound_two;

  logic [15:0] shift_word_next;
  logic [2:0]  shift_count_next;
  logic [7:0]  first_player_word_next;
  logic [7:0]  second_player_word_next;
  logic [7:0]  last_sound_one_next;
  logic [7:0]  last_sound_two_next;

  logic [3:0]  shift_amount;
  logic [15:0] shifted;
  logic [7:0]  mask;
  logic [7:0]  rise_one;
  logic [7:0]  fall_one;
  logic [7:0]  rise_two;

  // shift by 8 - count, so 1 to 8 bits
  assign shift_amount = aio_pkg::SHIFT_BASE - {1'b0, shift_count};
  assign shifted      = shift_word >> shift_amount;
  assign mask         = 8'd1 << item.button_bit;
  assign rise_one     = item.write_data & ~last_sound_one;
  assign fall_one     = ~item.write_data & last_sound_one;
  assign rise_two     = item.write_data & ~last_sound_two;

  always_comb begin
    shift_word_next         = shift_word;
    shift_count_next        = shift_count;
    first_player_word_next  = first_player_word;
    second_player_word_next = second_player_word;
    last_sound_one_next     = last_sound_one;
    last_sound_two_next     = last_sound_two;
    result                  = '0;
    case (item.operation)
      aio_pkg::OP_READ: begin
        case (item.port)
          aio_pkg::PORT_IN0:       result.read_data = aio_pkg::IN0_VALUE;
          aio_pkg::PORT_IN1:       result.read_data = first_player_word;
          aio_pkg::PORT_IN2:       result.read_data = second_player_word;
          aio_pkg::PORT_SHIFT_OUT: result.read_data = shifted[7:0];
          default:                 result.read_data = '0;
        endcase
      end
      aio_pkg::OP_WRITE: begin
        case (item.port)
          aio_pkg::PORT_SOUND_ONE: begin
            result.loop_start     = rise_one[0];
            result.loop_stop      = fall_one[0];
            result.sound_triggers = {5'd0, rise_one[3:1]};
            last_sound_one_next   = item.write_data;
          end
          aio_pkg::PORT_SOUND_TWO: begin
            result.sound_triggers = {rise_two[4:0], 3'd0};
            last_sound_two_next   = item.write_data;
          end
          aio_pkg::PORT_SHIFT_COUNT: begin
            shift_count_next = item.write_data[2:0] & aio_pkg::SHIFT_COUNT_MASK;
          end
          aio_pkg::PORT_SHIFT_DATA: begin
            shift_word_next = {item.write_data, shift_word[15:8]};
          end
          default: ;
        endcase
      end
      aio_pkg::OP_BUTTON: begin
        if (item.port == aio_pkg::PLAYER_ONE) begin
          first_player_word_next = item.pressed ? (first_player_word | mask)
                                                : (first_player_word & ~mask);
        end else if (item.port == aio_pkg::PLAYER_TWO) begin
          second_player_word_next = item.pressed ? (second_player_word | mask)
                                                 : (second_player_word & ~mask);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word         <= '0;
      shift_count        <= '0;
      first_player_word  <= '0;
      second_player_word <= aio_pkg::SECOND_WORD_RESET;
      last_sound_one     <= '0;
      last_sound_two     <= '0;
    end else if (fire) begin
      shift_word         <= shift_word_next;
      shift_count        <= shift_count_next;
      first_player_word  <= first_player_word_next;
      second_player_word <= second_player_word_next;
      last_sound_one     <= last_sound_one_next;
      last_sound_two     <= last_sound_two_next;
    end
  end

endmodule

// ===== hw/rtl/arcade_io_ports_shift_register.sv =====
// top level of the arcade i/o port block: input register, port logic, result register
//
//  channel  | dir | tdata / tuser
//  ---------+-----+-------------------------------------------------------------
//  s_       | in  | tdata: port, write_data, button_bit, pressed; tuser: operation
//  m_       | out | tdata: read_data, loop_start, loop_stop, sound_triggers
//
//  each access passes the input register and then the result register; one
//  transfer per cycle is sustained in both directions while m_tready is high
//  reset clears both valid flags and puts the port state to its power-up values
//  a stall on m_ holds the result; the input register then fills and s_tready
//  drops until the result register is free again
module arcade_io_ports_shift_register (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] port, [15:8] write_data, [18:16] button_bit, [19] pressed, rest zero
  input  logic [23:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] loop_start, [9] loop_stop, [17:10] sound_triggers, rest zero
  output logic [23:0] m_tdata
);

  aio_pkg::item_t   in_item;
  logic             in_valid;
  aio_pkg::result_t core_result;
  aio_pkg::result_t out_result;
  logic             out_free;
  logic             advance;

  // result register can take a new value when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  // the held item moves into the result register and updates port state
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation  <= s_tuser;
      in_item.port       <= s_tdata[7:0];
      in_item.write_data <= s_tdata[15:8];
      in_item.button_bit <= s_tdata[18:16];
      in_item.pressed    <= s_tdata[19];
    end
  end

  aio_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {6'd0, out_result.sound_triggers, out_result.loop_stop,
                    out_result.loop_start, out_result.read_data};

`ifndef ASSERT_OFF
  // a loop sound cannot start and stop on the same transfer
  a_start_stop_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_result.loop_start && out_result.loop_stop))
    else $error("loop start and stop both set");

  // read data and sound fields come from different operations
  a_read_or_sound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_result.read_data != 8'd0) |->
      (out_result.sound_triggers == 8'd0) && !out_result.loop_start && !out_result.loop_stop)
    else $error("read data and sound fields both active");

  // a held item is not dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid && m_tvalid)
    else $error("pending item lost during stall");

  // input is refused only when both registers are full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid)
    else $error("input refused with free register");
`endif

endmodule

// ===== sim/arcade_io_ports_result_watch.sv =====
// result checker for the arcade i/o port block: predicts every port access and compares results
`timescale 1ns / 1ps
module arcade_io_ports_result_watch
  import aio_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int unsigned failures,
  output int unsigned awaited,
  output int unsigned compared,
  output int unsigned sound_edges
);

  localparam int unsigned SHOWN_MISMATCHES = 10;

  // predicted port state
  logic [15:0] shift_word;
  logic [2:0]  shift_count;
  logic [7:0]  p1_buttons;
  logic [7:0]  p2_buttons;
  logic [7:0]  last_sound_one;
  logic [7:0]  last_sound_two;

  result_t     awaited_results[$];
  // two-state counters start at zero
  int unsigned fail_count;
  int unsigned compare_count;
  int unsigned edge_count;

  task automatic predict_port_access(input item_t acc, output result_t res);
    logic [15:0] shifted;
    logic [7:0]  rise;
    logic [7:0]  fall;
    logic [7:0]  mask;
    res  = '0;
    mask = 8'd1 << acc.button_bit;
    case (acc.operation)
      OP_READ: begin
        case (acc.port)
          PORT_IN0: res.read_data = IN0_VALUE;
          PORT_IN1: res.read_data = p1_buttons;
          PORT_IN2: res.read_data = p2_buttons;
          PORT_SHIFT_OUT: begin
            shifted = shift_word >> (SHIFT_BASE - {1'b0, shift_count & SHIFT_COUNT_MASK});
            res.read_data = shifted[7:0];
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (acc.port)
          PORT_SOUND_ONE: begin
            rise = acc.write_data & ~last_sound_one;
            fall = ~acc.write_data & last_sound_one;
            res.loop_start     = rise[0];
            res.loop_stop      = fall[0];
            res.sound_triggers = {5'd0, rise[3:1]};
            last_sound_one     = acc.write_data;
          end
          PORT_SOUND_TWO: begin
            rise = acc.write_data & ~last_sound_two;
            res.sound_triggers = {rise[4:0], 3'd0};
            last_sound_two     = acc.write_data;
          end
          PORT_SHIFT_COUNT: shift_count = acc.write_data[2:0] & SHIFT_COUNT_MASK;
          PORT_SHIFT_DATA:  shift_word  = {acc.write_data, shift_word[15:8]};
          default: ;
        endcase
      end
      OP_BUTTON: begin
        if (acc.port == PLAYER_ONE) begin
          p1_buttons = acc.pressed ? (p1_buttons | mask) : (p1_buttons & ~mask);
        end else if (acc.port == PLAYER_TWO) begin
          p2_buttons = acc.pressed ? (p2_buttons | mask) : (p2_buttons & ~mask);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    item_t   acc;
    result_t got;
    result_t want;
    if (rst) begin
      shift_word     = '0;
      shift_count    = '0;
      p1_buttons     = '0;
      p2_buttons     = SECOND_WORD_RESET;
      last_sound_one = '0;
      last_sound_two = '0;
      awaited_results.delete();
    end else begin
      // results first, so a result can never match an access taken at the same edge
      if (m_tvalid && m_tready) begin
        got.read_data      = m_tdata[7:0];
        got.loop_start     = m_tdata[8];
        got.loop_stop      = m_tdata[9];
        got.sound_triggers = m_tdata[17:10];
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES)
            $display("%0t: result with no access pending: tdata %h", $realtime, m_tdata);
        end else begin
          want = awaited_results.pop_front();
          compare_count++;
          if (want.loop_start || want.loop_stop || want.sound_triggers != 0)
            edge_count++;
          if (got.read_data != want.read_data || got.loop_start != want.loop_start ||
              got.loop_stop != want.loop_stop || got.sound_triggers != want.sound_triggers) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
              $display("%0t: mismatch: read %h start %b stop %b trig %h, expected %h %b %b %h",
                       $realtime, got.read_data, got.loop_start, got.loop_stop,
                       got.sound_triggers, want.read_data, want.loop_start, want.loop_stop,
                       want.sound_triggers);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc.operation  = s_tuser;
        acc.port       = s_tdata[7:0];
        acc.write_data = s_tdata[15:8];
        acc.button_bit = s_tdata[18:16];
        acc.pressed    = s_tdata[19];
        predict_port_access(acc, want);
        awaited_results.push_back(want);
      end
    end
    failures    <= fail_count;
    awaited     <= awaited_results.size();
    compared    <= compare_count;
    sound_edges <= edge_count;
  end

endmodule

// ===== sim/arcade_io_ports_shift_register_tb.sv =====
// testbench top for the arcade i/o port block: drives port accesses and gives the verdict
`timescale 1ns / 1ps
module arcade_io_ports_shift_register_tb;
  import aio_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  // a write-only port the block ignores
  localparam logic [7:0] PORT_WATCHDOG = 8'd6;

  localparam int unsigned RANDOM_ACCESSES = 1050;
  // accesses at the end of the run with no idling on either side
  localparam int unsigned QUIET_TAIL      = 150;
  localparam int unsigned PHASE_LEN       = 50;
  // sized for the longest sender idle and receiver stall on every access
  localparam int unsigned CYCLE_LIMIT     = 200000;
  // extra wait after the last result, with margin
  localparam int unsigned DRAIN_CYCLES    = 10;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [7:0] port, [15:8] write_data, [18:16] button_bit, [19] pressed, rest zero
  logic [23:0] s_tdata;
  // [1:0] operation
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // [7:0] read_data, [8] loop_start, [9] loop_stop, [17:10] sound_triggers, rest zero
  logic [23:0] m_tdata;

  int unsigned failures;
  int unsigned awaited;
  int unsigned compared;
  int unsigned sound_edges;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  // lets the result side stall; follows the phase the stimulus is in
  logic        bursts_on;

  arcade_io_ports_shift_register dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  arcade_io_ports_result_watch watch (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .failures    (failures),
    .awaited     (awaited),
    .compared    (compared),
    .sound_edges (sound_edges)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, awaited);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: ready by default, stalls in random bursts while allowed
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic item_t make_access(input logic [1:0] op, input logic [7:0] port,
                                        input logic [7:0] data, input logic [2:0] bit_pos,
                                        input logic pressed);
    item_t acc;
    acc.operation  = op;
    acc.port       = port;
    acc.write_data = data;
    acc.button_bit = bit_pos;
    acc.pressed    = pressed;
    return acc;
  endfunction

  // mostly well-formed accesses to the ports that matter, the rest noise
  function automatic item_t random_access();
    item_t       acc;
    int unsigned pick;
    acc.port       = 8'($urandom_range(0, 255));
    acc.write_data = 8'($urandom_range(0, 255));
    acc.button_bit = 3'($urandom_range(0, 7));
    acc.pressed    = 1'($urandom_range(0, 1));
    pick           = $urandom_range(0, 99);
    if (pick < 30) begin
      acc.operation = OP_READ;
      if (pick < 27) acc.port = 8'($urandom_range(0, 3));
    end else if (pick < 70) begin
      acc.operation = OP_WRITE;
      if (pick < 66) acc.port = 8'($urandom_range(2, 5));
    end else if (pick < 90) begin
      acc.operation = OP_BUTTON;
      if (pick < 87) acc.port = 8'($urandom_range(1, 2));
    end else begin
      acc.operation = 2'($urandom_range(0, 3));
    end
    return acc;
  endfunction

  // holds the transfer until the block takes it; valid stays high for the next call
  task automatic push_access(input item_t acc);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, acc.pressed, acc.button_bit, acc.write_data, acc.port};
    s_tuser  <= acc.operation;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    item_t acc;
    logic  idle_phase;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    bursts_on <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: power-up values, shifter extremes, sound edges, buttons, ignored accesses
    push_access(make_access(OP_READ, PORT_IN0, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_READ, PORT_IN2, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_READ, PORT_SHIFT_OUT, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SHIFT_DATA, 8'hA5, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SHIFT_DATA, 8'hFF, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SHIFT_COUNT, 8'h07, 3'd0, 1'b0));
    push_access(make_access(OP_READ, PORT_SHIFT_OUT, 8'h00, 3'd0, 1'b0));
    // count takes only the low three bits
    push_access(make_access(OP_WRITE, PORT_SHIFT_COUNT, 8'hF8, 3'd0, 1'b0));
    push_access(make_access(OP_READ, PORT_SHIFT_OUT, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SOUND_ONE, 8'hFF, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SOUND_ONE, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SOUND_TWO, 8'hFF, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_SOUND_TWO, 8'hE0, 3'd0, 1'b0));
    push_access(make_access(OP_BUTTON, PLAYER_ONE, 8'h00, 3'd7, 1'b1));
    push_access(make_access(OP_BUTTON, PLAYER_ONE, 8'h00, 3'd0, 1'b1));
    push_access(make_access(OP_READ, PORT_IN1, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_BUTTON, PLAYER_TWO, 8'h00, 3'd0, 1'b0));
    // button change on a port with no player word
    push_access(make_access(OP_BUTTON, 8'd0, 8'h00, 3'd3, 1'b1));
    push_access(make_access(OP_READ, PORT_IN2, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_WRITE, PORT_WATCHDOG, 8'h55, 3'd0, 1'b0));
    push_access(make_access(OP_UNUSED, 8'hFF, 8'hFF, 3'd7, 1'b1));
    push_access(make_access(OP_READ, 8'hFF, 8'h00, 3'd0, 1'b0));
    push_access(make_access(OP_BUTTON, 8'hFF, 8'h00, 3'd7, 1'b0));
    push_access(make_access(OP_WRITE, 8'd0, 8'hFF, 3'd0, 1'b0));

    // random accesses, idling switched on and off by phase, none at the tail
    idle_phase = 1'b0;
    for (int unsigned i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i % PHASE_LEN == 0) begin
        idle_phase = (i < RANDOM_ACCESSES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
        bursts_on <= idle_phase;
      end
      acc = random_access();
      push_access(acc);
      if (idle_phase && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d port accesses (reads, writes, button changes, ignored codes)",
             sent);
    $display("%0d results compared, %0d of them with sound edges", compared, sound_edges);
    if (failures == 0 && awaited == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
